// File: hdl/swrb_pkg.sv
// Shared constants and codes for the send window retransmit buffer.
`timescale 1ns / 1ps
package swrb_pkg;

    localparam int DEF_MAX_WINDOW = 4096;
    localparam int DEF_MAX_FETCH  = 64;
    localparam int WIN_RESET      = 4096;

    localparam int CFG_W    = 13;
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int SEQ_W    = 32;
    localparam int LEN_W    = 7;
    localparam int STAT_W   = 2;
    localparam int FREE_W   = 13;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FETCH = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ACK_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

endpackage

// File: hdl/send_window_retransmit_buffer.sv
// Sender-side sliding window byte store with cumulative acknowledge and resend fetch.
//
//  channel | ports                          | payload (low bit first)
//  --------+--------------------------------+-----------------------------------------------
//  input   | s_tvalid s_tready s_tdata/tuser| tdata: data_byte, ack_seq, fetch_len; tuser: kind
//  result  | m_tvalid m_tready m_tdata/tuser| tdata: out_byte, byte_seq, free_space;
//          |   m_tlast                      |   tuser: status; tlast: last
//  config  | cfg_wr_en cfg_wr_data          | window_size
//
// Add, unknown kind and empty fetch: RESULT loads the result register, then back to IDLE.
// Acknowledge: sequence difference, then pointer update in ACK_APPLY, then RESULT.
// Fetch of n bytes: FETCH_SETUP, then FETCH_RUN reads one byte per cycle from
// the single-port store while no result stalls; next input once the last byte has left the read stage.
// A waiting result holds the pipeline and the input until m_tready.
// Reset is synchronous, active low; the store itself is not cleared.
`timescale 1ns / 1ps
module send_window_retransmit_buffer
    import swrb_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int MAX_FETCH  = DEF_MAX_FETCH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // data_byte[7:0], ack_seq[39:8], fetch_len[46:40]
    input  logic [KIND_W-1:0]    s_tuser,   // kind[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_byte[7:0], byte_seq[39:8], free_space[52:40]
    output logic [STAT_W-1:0]    m_tuser,   // status[1:0]
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    localparam int IW = $clog2(MAX_WINDOW);
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int CW = $clog2(MAX_FETCH + 1);
    localparam int WIN_RST = (MAX_WINDOW < WIN_RESET) ? MAX_WINDOW : WIN_RESET;

    typedef enum logic [2:0] {
        IDLE,
        ACK_APPLY,
        FETCH_SETUP,
        FETCH_RUN,
        RESULT
    } state_t;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                               input logic [WW-1:0] b,
                                               input logic [WW-1:0] w);
        logic [WW:0] s;
        s = (WW+1)'(a) + (WW+1)'(b);
        if (s >= (WW+1)'(w)) begin
            s = s - (WW+1)'(w);
        end
        return IW'(s);
    endfunction

    logic [BYTE_W-1:0] mem [MAX_WINDOW];

    state_t            state_reg, state_next;
    logic [WW-1:0]     win_reg, win_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [IW-1:0]     tail_reg, tail_next;
    logic [WW-1:0]     occ_reg, occ_next;
    logic [IW-1:0]     roff_reg, roff_next;
    logic [SEQ_W-1:0]  head_seq_reg, head_seq_next;

    logic [SEQ_W-1:0]  d_reg, d_next;
    logic [SEQ_W-1:0]  ack_reg, ack_next;
    logic [CW-1:0]     len_reg, len_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [IW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [SEQ_W-1:0]  res_seq_reg, res_seq_next;

    logic              a_valid_reg, a_valid_next;
    logic [SEQ_W-1:0]  a_seq_reg, a_seq_next;
    logic              a_last_reg, a_last_next;
    logic [BYTE_W-1:0] rdata_reg;

    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [BYTE_W-1:0] m_byte_reg, m_byte_next;
    logic [SEQ_W-1:0]  m_seq_reg, m_seq_next;
    logic [FREE_W-1:0] m_free_reg, m_free_next;
    logic              m_last_reg, m_last_next;

    logic              s_accept;
    logic              b_adv;
    logic              a_adv;
    logic              issue;
    logic              mem_we;
    logic [BYTE_W-1:0] in_byte;
    logic [SEQ_W-1:0]  in_ack;
    logic [LEN_W-1:0]  in_len;
    logic [IW-1:0]     ack_head;
    logic [IW-1:0]     f_off;
    logic [WW-1:0]     f_avail;
    logic [CW-1:0]     f_n;
    logic [FREE_W-1:0] free_now;

    assign in_byte  = s_tdata[7:0];
    assign in_ack   = s_tdata[39:8];
    assign in_len   = s_tdata[46:40];

    assign s_tready = (state_reg == IDLE) && !a_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign b_adv    = !m_valid_reg || m_tready;
    assign a_adv    = a_valid_reg && b_adv;
    assign issue    = (state_reg == FETCH_RUN) && (!a_valid_reg || b_adv);
    assign free_now = FREE_W'(win_reg - occ_reg);

    assign ack_head = wrap_add(head_reg, WW'(d_reg), win_reg);
    assign f_off    = (WW'(roff_reg) < occ_reg) ? roff_reg : '0;
    assign f_avail  = occ_reg - WW'(f_off);
    assign f_n      = (32'(len_reg) < 32'(f_avail)) ? len_reg : CW'(f_avail);

    always_comb begin
        state_next      = state_reg;
        win_next        = win_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        roff_next       = roff_reg;
        head_seq_next   = head_seq_reg;
        d_next          = d_reg;
        ack_next        = ack_reg;
        len_next        = len_reg;
        rem_next        = rem_reg;
        rd_ptr_next     = rd_ptr_reg;
        seq_next        = seq_reg;
        res_status_next = res_status_reg;
        res_seq_next    = res_seq_reg;
        a_seq_next      = a_seq_reg;
        a_last_next     = a_last_reg;
        mem_we          = 1'b0;

        case (state_reg)
            IDLE: begin
                if (s_accept) begin
                    res_seq_next = '0;
                    case (s_tuser)
                        KIND_ADD: begin
                            if (occ_reg >= win_reg) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                mem_we          = 1'b1;
                                tail_next       = wrap_add(tail_reg, WW'(1), win_reg);
                                occ_next        = occ_reg + WW'(1);
                                res_status_next = STAT_OK;
                            end
                            state_next = RESULT;
                        end
                        KIND_ACK: begin
                            d_next     = in_ack - head_seq_reg;
                            ack_next   = in_ack;
                            state_next = ACK_APPLY;
                        end
                        KIND_FETCH: begin
                            if (occ_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                                res_seq_next    = head_seq_reg;
                                state_next      = RESULT;
                            end else begin
                                if (in_len == '0) begin
                                    len_next = CW'(1);
                                end else if (32'(in_len) > MAX_FETCH) begin
                                    len_next = CW'(MAX_FETCH);
                                end else begin
                                    len_next = CW'(in_len);
                                end
                                state_next = FETCH_SETUP;
                            end
                        end
                        default: begin
                            res_status_next = STAT_OK;
                            state_next      = RESULT;
                        end
                    endcase
                end
            end
            ACK_APPLY: begin
                if (d_reg > 32'(occ_reg)) begin
                    res_status_next = STAT_ACK_RANGE;
                end else begin
                    head_next     = ack_head;
                    head_seq_next = ack_reg;
                    occ_next      = occ_reg - WW'(d_reg);
                    if (32'(roff_reg) >= d_reg && WW'(roff_reg) < occ_reg) begin
                        roff_next = IW'(32'(roff_reg) - d_reg);
                    end else begin
                        roff_next = '0;
                    end
                    if (d_reg == 32'(occ_reg)) begin
                        tail_next = ack_head;
                    end
                    res_status_next = STAT_OK;
                end
                state_next = RESULT;
            end
            FETCH_SETUP: begin
                rem_next    = f_n;
                rd_ptr_next = wrap_add(head_reg, WW'(f_off), win_reg);
                seq_next    = head_seq_reg + SEQ_W'(f_off);
                if (32'(f_off) + 32'(f_n) >= 32'(occ_reg)) begin
                    roff_next = '0;
                end else begin
                    roff_next = IW'(32'(f_off) + 32'(f_n));
                end
                state_next = FETCH_RUN;
            end
            FETCH_RUN: begin
                if (issue) begin
                    a_seq_next  = seq_reg;
                    a_last_next = (rem_reg == CW'(1));
                    rd_ptr_next = wrap_add(rd_ptr_reg, WW'(1), win_reg);
                    seq_next    = seq_reg + SEQ_W'(1);
                    rem_next    = rem_reg - CW'(1);
                    if (rem_reg == CW'(1)) begin
                        state_next = IDLE;
                    end
                end
            end
            RESULT: begin
                if (b_adv) begin
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                win_next = WW'(1);
            end else if (32'(cfg_wr_data) > MAX_WINDOW) begin
                win_next = WW'(MAX_WINDOW);
            end else begin
                win_next = WW'(cfg_wr_data);
            end
            head_next = '0;
            tail_next = '0;
            occ_next  = '0;
            roff_next = '0;
        end
    end

    always_comb begin
        a_valid_next  = issue ? 1'b1 : (a_adv ? 1'b0 : a_valid_reg);
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_byte_next   = m_byte_reg;
        m_seq_next    = m_seq_reg;
        m_free_next   = m_free_reg;
        m_last_next   = m_last_reg;
        if (b_adv) begin
            m_valid_next = 1'b0;
            if (a_valid_reg) begin
                m_valid_next  = 1'b1;
                m_status_next = STAT_OK;
                m_byte_next   = rdata_reg;
                m_seq_next    = a_seq_reg;
                m_free_next   = free_now;
                m_last_next   = a_last_reg;
            end else if (state_reg == RESULT) begin
                m_valid_next  = 1'b1;
                m_status_next = res_status_reg;
                m_byte_next   = '0;
                m_seq_next    = res_seq_reg;
                m_free_next   = free_now;
                m_last_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[tail_reg] <= in_byte;
        end
        if (issue) begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            win_reg      <= WW'(WIN_RST);
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= '0;
            roff_reg     <= '0;
            head_seq_reg <= '0;
            a_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            win_reg      <= win_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            occ_reg      <= occ_next;
            roff_reg     <= roff_next;
            head_seq_reg <= head_seq_next;
            a_valid_reg  <= a_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        d_reg          <= d_next;
        ack_reg        <= ack_next;
        len_reg        <= len_next;
        rem_reg        <= rem_next;
        rd_ptr_reg     <= rd_ptr_next;
        seq_reg        <= seq_next;
        res_status_reg <= res_status_next;
        res_seq_reg    <= res_seq_next;
        a_seq_reg      <= a_seq_next;
        a_last_reg     <= a_last_next;
        m_status_reg   <= m_status_next;
        m_byte_reg     <= m_byte_next;
        m_seq_reg      <= m_seq_next;
        m_free_reg     <= m_free_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_free_reg, m_seq_reg, m_byte_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: hdl/swrb_checker.sv
// Port-level checks for the send window retransmit buffer, bound to the top level.
`timescale 1ns / 1ps
module swrb_checker
    import swrb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]    m_tuser,
    input logic                 m_tlast
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result transaction changed");

    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tlast)
        else $error("flagged result is not the final one");

    a_err_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata[7:0] == 8'd0)
        else $error("flagged result carries a byte");

    a_run_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken in the middle of a fetch run");

endmodule

bind send_window_retransmit_buffer swrb_checker u_swrb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: dv/tb_send_window_retransmit_buffer.sv
// Self-checking testbench for the send window retransmit buffer, directed table then random.
`timescale 1ns / 1ps
module tb_send_window_retransmit_buffer;
    import swrb_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int SH_IW         = $clog2(DEF_MAX_WINDOW);

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [SEQ_W-1:0]  ack;
        logic [LEN_W-1:0]  len;
    } win_req_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] out_byte;
        logic [SEQ_W-1:0]  seq;
        logic [FREE_W-1:0] free;
        logic              last;
    } win_rsp_t;

    typedef struct {
        bit               wr_cfg;
        logic [CFG_W-1:0] cfg;
        win_req_t         req;
        bit               typed;
        win_rsp_t         rsp;
    } plan_row_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [KIND_W-1:0]    s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    send_window_retransmit_buffer u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // shadow copy of the window
    logic [BYTE_W-1:0] shadow_bytes [DEF_MAX_WINDOW];
    logic [CFG_W-1:0]  win_reg    = CFG_W'(WIN_RESET);
    int unsigned       head_ix    = 0;
    int unsigned       tail_ix    = 0;
    int unsigned       resend_ix  = 0;
    bit                win_empty  = 1'b1;
    logic [SEQ_W-1:0]  oldest_seq = '0;
    win_rsp_t          results_due [$];

    int src_idle_pct = 27;
    int dst_idle_pct = 76;
    int hold_asked   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int fails        = 0;

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fails++;
    endtask

    function automatic int unsigned live_win();
        if (win_reg == 0) return 1;
        if (win_reg > DEF_MAX_WINDOW) return DEF_MAX_WINDOW;
        return 32'(win_reg);
    endfunction

    function automatic int unsigned bytes_held();
        int unsigned w;
        w = live_win();
        if (win_empty) return 0;
        if (tail_ix == head_ix) return w;
        return (tail_ix + w - head_ix) % w;
    endfunction

    function automatic int unsigned span_offset(input int unsigned idx);
        int unsigned w;
        w = live_win();
        return (idx + w - head_ix) % w;
    endfunction

    task automatic post_result(input logic [STAT_W-1:0] st, input logic [BYTE_W-1:0] b,
                               input logic [SEQ_W-1:0] sq, input bit fin);
        win_rsp_t r;
        r.status   = st;
        r.out_byte = b;
        r.seq      = sq;
        r.free     = FREE_W'(live_win() - bytes_held());
        r.last     = fin;
        results_due.push_back(r);
    endtask

    task automatic apply_window_op(input win_req_t r);
        int unsigned w, occ, off, avail, n, cnt, i;
        logic [SEQ_W-1:0] d;
        w = live_win();
        case (r.kind)
            KIND_ADD: begin
                if (bytes_held() >= w) begin
                    post_result(STAT_FULL, '0, '0, 1'b1);
                end else begin
                    shadow_bytes[SH_IW'(tail_ix)] = r.data;
                    tail_ix = (tail_ix + 1) % w;
                    win_empty = 1'b0;
                    post_result(STAT_OK, '0, '0, 1'b1);
                end
            end
            KIND_ACK: begin
                occ = bytes_held();
                d = r.ack - oldest_seq;
                if (d > occ) begin
                    post_result(STAT_ACK_RANGE, '0, '0, 1'b1);
                end else begin
                    head_ix = (head_ix + d) % w;
                    oldest_seq = r.ack;
                    if (d == occ) begin
                        win_empty = 1'b1;
                        tail_ix = head_ix;
                        resend_ix = head_ix;
                    end else if (span_offset(resend_ix) >= occ - d) begin
                        resend_ix = head_ix;
                    end
                    post_result(STAT_OK, '0, '0, 1'b1);
                end
            end
            KIND_FETCH: begin
                cnt = 32'(r.len);
                if (cnt == 0) cnt = 1;
                if (cnt > DEF_MAX_FETCH) cnt = DEF_MAX_FETCH;
                occ = bytes_held();
                if (occ == 0) begin
                    post_result(STAT_EMPTY, '0, oldest_seq, 1'b1);
                end else begin
                    off = span_offset(resend_ix);
                    if (off >= occ) begin
                        resend_ix = head_ix;
                        off = 0;
                    end
                    avail = occ - off;
                    n = (cnt < avail) ? cnt : avail;
                    for (i = 0; i < n; i++) begin
                        post_result(STAT_OK, shadow_bytes[SH_IW'((resend_ix + i) % w)],
                                    oldest_seq + off + i, (i + 1) == n);
                    end
                    if (off + n >= occ) resend_ix = head_ix;
                    else resend_ix = (resend_ix + n) % w;
                end
            end
            default: begin
                post_result(STAT_OK, '0, '0, 1'b1);
            end
        endcase
    endtask

    function automatic win_req_t next_req();
        win_req_t r;
        int unsigned pick;
        r.kind = KIND_ADD;
        r.data = BYTE_W'($urandom);
        r.ack  = $urandom;
        r.len  = LEN_W'($urandom);
        pick   = $urandom_range(99);
        if (pick < 45) begin
            r.kind = KIND_ADD;
        end else if (pick < 65) begin
            r.kind = KIND_FETCH;
            if ($urandom_range(9) < 8) r.len = LEN_W'($urandom_range(16, 1));
        end else if (pick < 88) begin
            r.kind = KIND_ACK;
            r.ack  = oldest_seq + $urandom_range(bytes_held());
        end else if (pick < 96) begin
            r.kind = KIND_ACK;
        end else begin
            r.kind = KIND_NONE;
        end
        return r;
    endfunction

    function automatic plan_row_t plan_step(input bit wr, input logic [CFG_W-1:0] wv,
                                            input logic [KIND_W-1:0] k,
                                            input logic [BYTE_W-1:0] b,
                                            input logic [SEQ_W-1:0] a,
                                            input logic [LEN_W-1:0] l, input bit t,
                                            input logic [STAT_W-1:0] st,
                                            input logic [SEQ_W-1:0] sq,
                                            input logic [FREE_W-1:0] fr);
        plan_row_t p;
        p.wr_cfg       = wr;
        p.cfg          = wv;
        p.req.kind     = k;
        p.req.data     = b;
        p.req.ack      = a;
        p.req.len      = l;
        p.typed        = t;
        p.rsp.status   = st;
        p.rsp.out_byte = '0;
        p.rsp.seq      = sq;
        p.rsp.free     = fr;
        p.rsp.last     = 1'b1;
        return p;
    endfunction

    task automatic send_req(input win_req_t r, input bit typed, input win_rsp_t want);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {1'b0, r.len, r.ack, r.data};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        apply_window_op(r);
        if (typed) begin
            results_due.delete(results_due.size() - 1);
            results_due.push_back(want);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] v);
        drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        win_reg   = v;
        head_ix   = 0;
        tail_ix   = 0;
        resend_ix = 0;
        win_empty = 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int items, input int src, input int dst,
                             input logic [CFG_W-1:0] wsz, input bit squeeze);
        win_req_t r;
        win_rsp_t none;
        int made;
        none = '{default: '0};
        made = 0;
        write_window(wsz);
        src_idle_pct = src;
        dst_idle_pct = dst;
        if (squeeze) hold_asked++;
        while (made < items) begin
            r = next_req();
            send_req(r, 1'b0, none);
            if (r.kind != KIND_NONE) made++;
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [SEQ_W-1:0] got,
                               input logic [SEQ_W-1:0] want);
        if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    always @(posedge aclk) begin : watch_results
        win_rsp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                report("result transaction with nothing outstanding");
            end else begin
                want = results_due.pop_front();
                check_field("status", SEQ_W'(m_tuser), SEQ_W'(want.status));
                check_field("out_byte", SEQ_W'(m_tdata[7:0]), SEQ_W'(want.out_byte));
                check_field("byte_seq", m_tdata[39:8], want.seq);
                check_field("free_space", SEQ_W'(m_tdata[52:40]), SEQ_W'(want.free));
                check_field("last", SEQ_W'(m_tlast), SEQ_W'(want.last));
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("timeout with %0d results outstanding", results_due.size());
        $display("tb_send_window_retransmit_buffer: done, errors");
        $finish;
    end

    initial begin
        plan_row_t plan [$];
        plan.push_back(plan_step(0, 0, KIND_FETCH, 8'h00, 32'd0, 7'd1, 1, STAT_EMPTY, 0, 4096));
        plan.push_back(plan_step(0, 0, KIND_NONE, 8'h00, 32'd0, 7'd0, 1, STAT_OK, 0, 4096));
        plan.push_back(plan_step(0, 0, KIND_ACK, 8'h00, 32'd0, 7'd0, 1, STAT_OK, 0, 4096));
        plan.push_back(plan_step(0, 0, KIND_ACK, 8'h00, 32'd1, 7'd0, 1, STAT_ACK_RANGE, 0, 4096));
        plan.push_back(plan_step(1, 2, KIND_ADD, 8'h00, 32'd0, 7'd0, 0, STAT_OK, 0, 0));
        plan.push_back(plan_step(0, 0, KIND_ADD, 8'h00, 32'd0, 7'd0, 1, STAT_OK, 0, 1));
        plan.push_back(plan_step(0, 0, KIND_ADD, 8'hFF, 32'd0, 7'd0, 1, STAT_OK, 0, 0));
        plan.push_back(plan_step(0, 0, KIND_ADD, 8'hA5, 32'd0, 7'd0, 1, STAT_FULL, 0, 0));
        plan.push_back(plan_step(0, 0, KIND_FETCH, 8'h00, 32'd0, 7'd0, 0, STAT_OK, 0, 0));
        plan.push_back(plan_step(0, 0, KIND_FETCH, 8'h00, 32'd0, 7'd127, 0, STAT_OK, 0, 0));
        plan.push_back(plan_step(0, 0, KIND_ACK, 8'h00, 32'hFFFF_FFFF, 7'd0, 1,
                                 STAT_ACK_RANGE, 0, 0));
        plan.push_back(plan_step(0, 0, KIND_ACK, 8'h00, 32'd1, 7'd0, 1, STAT_OK, 0, 1));
        plan.push_back(plan_step(0, 0, KIND_ACK, 8'h00, 32'd3, 7'd0, 1, STAT_ACK_RANGE, 0, 1));
        plan.push_back(plan_step(0, 0, KIND_ACK, 8'h00, 32'd2, 7'd0, 1, STAT_OK, 0, 2));
        plan.push_back(plan_step(0, 0, KIND_FETCH, 8'h00, 32'd0, 7'd5, 1, STAT_EMPTY, 2, 2));
        plan.push_back(plan_step(1, 0, KIND_ADD, 8'h00, 32'd0, 7'd0, 0, STAT_OK, 0, 0));
        plan.push_back(plan_step(0, 0, KIND_ADD, 8'h5A, 32'd0, 7'd0, 1, STAT_OK, 0, 0));
        plan.push_back(plan_step(0, 0, KIND_ADD, 8'h11, 32'd0, 7'd0, 1, STAT_FULL, 0, 0));
        plan.push_back(plan_step(0, 0, KIND_FETCH, 8'h00, 32'd0, 7'd64, 0, STAT_OK, 0, 0));
        plan.push_back(plan_step(1, 8191, KIND_ADD, 8'h00, 32'd0, 7'd0, 0, STAT_OK, 0, 0));
        plan.push_back(plan_step(0, 0, KIND_ADD, 8'h3C, 32'd0, 7'd0, 1, STAT_OK, 0, 4095));
        plan.push_back(plan_step(0, 0, KIND_ADD, 8'hC3, 32'd0, 7'd0, 1, STAT_OK, 0, 4094));
        plan.push_back(plan_step(0, 0, KIND_ADD, 8'h96, 32'd0, 7'd0, 1, STAT_OK, 0, 4093));
        plan.push_back(plan_step(0, 0, KIND_FETCH, 8'h00, 32'd0, 7'd1, 0, STAT_OK, 0, 0));
        plan.push_back(plan_step(0, 0, KIND_ACK, 8'h00, 32'd4, 7'd0, 1, STAT_OK, 0, 4095));
        plan.push_back(plan_step(0, 0, KIND_FETCH, 8'h00, 32'd0, 7'd64, 0, STAT_OK, 0, 0));

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].wr_cfg) write_window(plan[i].cfg);
            else send_req(plan[i].req, plan[i].typed, plan[i].rsp);
        end

        run_phase(36, 27, 76, CFG_W'($urandom_range(12, 1)), 1'b0);
        run_phase(36, 76, 27, CFG_W'($urandom_range(200, 13)), 1'b0);
        run_phase(36, 0, 0, CFG_W'($urandom_range(8190, 4097)), 1'b1);

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fails == 0) begin
            $display("tb_send_window_retransmit_buffer: done, clean");
        end else begin
            $display("tb_send_window_retransmit_buffer: done, errors");
        end
        $finish;
    end

endmodule
